// ===== hdl/ddrc_pkg.sv =====
// Shared types and constants for the differential drive ramp controller.
// Holds the command codes, the queue entry layout and the back-end states.
// No dependencies.
package ddrc_pkg;

   // Field widths
   localparam int PCT_W      = 16;
   localparam int WHEEL_W    = 9;
   localparam int PWM_W      = 8;
   localparam int STEP_W     = 8;
   localparam int INTERVAL_W = 16;
   localparam int OFS_W      = 8;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_PWM       = 2'd0,
      REG_RAMP_STEP     = 2'd1,
      REG_RAMP_INTERVAL = 2'd2
   } reg_index_type;

   localparam logic [PWM_W-1:0]      MAX_PWM_RESET       = 8'd200;
   localparam logic [STEP_W-1:0]     RAMP_STEP_RESET     = 8'd8;
   localparam logic [INTERVAL_W-1:0] RAMP_INTERVAL_RESET = 16'd20;

   // Command codes
   typedef enum logic [2:0] {
      CMD_TICK       = 3'd0,
      CMD_DRIVE      = 3'd1,
      CMD_SET_TARGET = 3'd2,
      CMD_SOFT_STOP  = 3'd3,
      CMD_STOP       = 3'd4,
      CMD_ESTOP      = 3'd5,
      CMD_CLEAR      = 3'd6
   } cmd_type;

   // Percent clamp limit
   localparam logic signed [PCT_W-1:0] PCT_LIMIT = 16'sd100;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Arithmetic: shared multiplier, reciprocal of 100, scaling divider
   localparam int MUL_W       = 17;
   localparam int PROD_W      = 17;
   localparam int BIG_W       = 10;
   localparam int REC_Q_W     = 10;
   localparam int RECIP_SHIFT = 23;
   localparam logic [MUL_W-1:0] RECIP_100 = 17'd83887;

   // One classified command waiting for the back end
   typedef struct packed {
      logic [2:0]                 cmd;
      logic [OFS_W-1:0]           fwd_ofs;
      logic [OFS_W-1:0]           turn_ofs;
      logic signed [WHEEL_W-1:0]  left_goal;
      logic signed [WHEEL_W-1:0]  right_goal;
      logic                       driver_ok;
   } entry_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MUL_F,
      BK_REC_F,
      BK_MUL_T,
      BK_REC_T,
      BK_MIX,
      BK_MUL_L,
      BK_DIV_L,
      BK_MUL_R,
      BK_DIV_R,
      BK_FINISH
   } back_state_type;

endpackage

// ===== hdl/ddrc_front.sv =====
// Front end: takes command beats and classifies them into queue entries.
// Clamps percent demands and wheel targets. Depends on ddrc_pkg.
module ddrc_front (
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_command,
   input  logic signed [ddrc_pkg::PCT_W-1:0]   req_forward_percent,
   input  logic signed [ddrc_pkg::PCT_W-1:0]   req_turn_percent,
   input  logic signed [ddrc_pkg::PCT_W-1:0]   req_left_request,
   input  logic signed [ddrc_pkg::PCT_W-1:0]   req_right_request,
   input  logic                                req_driver_ok,
   input  logic [ddrc_pkg::PWM_W-1:0]          max_pwm,
   input  logic                                queue_full,
   output logic                                push,
   output ddrc_pkg::entry_type                 entry
);

   // Clamp a percent to +-100 and offset it to 0..200
   function automatic logic [ddrc_pkg::OFS_W-1:0] pct_offset(
      input logic signed [ddrc_pkg::PCT_W-1:0] pct);
      logic signed [ddrc_pkg::PCT_W-1:0] c;
      logic signed [ddrc_pkg::PCT_W-1:0] s;
      c = pct;
      if (pct < -ddrc_pkg::PCT_LIMIT) c = -ddrc_pkg::PCT_LIMIT;
      if (pct > ddrc_pkg::PCT_LIMIT) c = ddrc_pkg::PCT_LIMIT;
      s = c + ddrc_pkg::PCT_LIMIT;
      return s[ddrc_pkg::OFS_W-1:0];
   endfunction

   // Clamp a wheel request to +-max_pwm
   function automatic logic signed [ddrc_pkg::WHEEL_W-1:0] clamp_goal(
      input logic signed [ddrc_pkg::PCT_W-1:0] v,
      input logic [ddrc_pkg::PWM_W-1:0]        m);
      logic signed [ddrc_pkg::PCT_W-1:0] hi;
      logic signed [ddrc_pkg::PCT_W-1:0] lo;
      logic signed [ddrc_pkg::PCT_W-1:0] c;
      hi = $signed({{(ddrc_pkg::PCT_W-ddrc_pkg::PWM_W){1'b0}}, m});
      lo = -hi;
      c  = v;
      if (v < lo) c = lo;
      if (v > hi) c = hi;
      return c[ddrc_pkg::WHEEL_W-1:0];
   endfunction

   // Hold the channel while the queue is full
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Build the queue entry
   always_comb begin
      entry.cmd        = req_command;
      entry.fwd_ofs    = pct_offset(req_forward_percent);
      entry.turn_ofs   = pct_offset(req_turn_percent);
      entry.left_goal  = clamp_goal(req_left_request, max_pwm);
      entry.right_goal = clamp_goal(req_right_request, max_pwm);
      entry.driver_ok  = req_driver_ok;
   end

endmodule

// ===== hdl/ddrc_fifo.sv =====
// Short command queue between the front and back ends.
// Register-based ring buffer of entry_type. Depends on ddrc_pkg.
module ddrc_fifo #(
   parameter int DEPTH = ddrc_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ddrc_pkg::entry_type push_entry,
   input  logic                pop,
   output ddrc_pkg::entry_type head,
   output logic                full,
   output logic                empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ddrc_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

endmodule

// ===== hdl/ddrc_div.sv =====
// Restoring divider, one quotient bit per cycle, for wheel scaling.
// Unsigned operands; divisor must be nonzero. No package dependency beyond defaults.
module ddrc_div #(
   parameter int DIVIDEND_W = ddrc_pkg::PROD_W,
   parameter int DIVISOR_W  = ddrc_pkg::BIG_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsor_ff, dsor_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   assign shifted  = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff     = shifted - {1'b0, dsor_ff};
   assign fits     = (shifted >= {1'b0, dsor_ff});
   assign done     = busy_ff && (cnt_ff == '0);
   assign quotient = quo_ff;

   // Load on start, shift-subtract until the count runs out
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsor_in = dsor_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         quo_in  = dividend;
         dsor_in = divisor;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsor_ff <= dsor_in;
   end

endmodule

// ===== hdl/ddrc_back.sv =====
// Back end: executes queued commands, holds wheel state and the result register.
// Drive mixing uses one shared multiplier and the ddrc_div unit. Depends on ddrc_pkg.
module ddrc_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ddrc_pkg::entry_type                     head,
   input  logic                                    queue_empty,
   output logic                                    pop,
   input  logic [ddrc_pkg::PWM_W-1:0]              max_pwm,
   input  logic [ddrc_pkg::STEP_W-1:0]             ramp_step,
   input  logic [ddrc_pkg::INTERVAL_W-1:0]         ramp_interval,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_accepted,
   output logic signed [ddrc_pkg::WHEEL_W-1:0]     rsp_left_drive,
   output logic signed [ddrc_pkg::WHEEL_W-1:0]     rsp_right_drive,
   output logic                                    rsp_speeds_issued,
   output logic                                    rsp_stop_issued,
   output logic                                    rsp_halted
);

   localparam int W  = ddrc_pkg::WHEEL_W;
   localparam int MW = ddrc_pkg::MUL_W;
   localparam int BW = ddrc_pkg::BIG_W;

   // Step a level toward its goal by at most step
   function automatic logic signed [W-1:0] move_toward(
      input logic signed [W-1:0]             cur,
      input logic signed [W-1:0]             goal,
      input logic [ddrc_pkg::STEP_W-1:0]     step);
      logic signed [W+1:0] c;
      logic signed [W+1:0] g;
      logic signed [W+1:0] s;
      logic signed [W+1:0] n;
      c = (W+2)'(cur);
      g = (W+2)'(goal);
      s = $signed({{(W+2-ddrc_pkg::STEP_W){1'b0}}, step});
      n = c;
      if (c < g) begin
         n = c + s;
         if (n > g) n = g;
      end else if (c > g) begin
         n = c - s;
         if (n < g) n = g;
      end
      return n[W-1:0];
   endfunction

   ddrc_pkg::back_state_type state_ff, state_in;
   ddrc_pkg::entry_type      item_ff, item_in;

   // Drive datapath
   logic [MW-1:0]           acc_ff, acc_in;
   logic signed [BW-1:0]    f_ff, f_in;
   logic signed [BW-1:0]    t_ff, t_in;
   logic [BW-1:0]           mag_l_ff, mag_l_in;
   logic [BW-1:0]           mag_r_ff, mag_r_in;
   logic                    neg_l_ff, neg_l_in;
   logic                    neg_r_ff, neg_r_in;
   logic [BW-1:0]           big_ff, big_in;
   logic signed [W-1:0]     drv_l_ff, drv_l_in;
   logic signed [W-1:0]     drv_r_ff, drv_r_in;

   // Architectural state
   logic signed [W-1:0]     goal_l_ff, goal_l_in;
   logic signed [W-1:0]     goal_r_ff, goal_r_in;
   logic signed [W-1:0]     level_l_ff, level_l_in;
   logic signed [W-1:0]     level_r_ff, level_r_in;
   logic                    halt_ff, halt_in;
   logic [ddrc_pkg::INTERVAL_W-1:0] elapsed_ff, elapsed_in;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_accepted_ff, rsp_accepted_in;
   logic signed [W-1:0]     rsp_left_ff, rsp_left_in;
   logic signed [W-1:0]     rsp_right_ff, rsp_right_in;
   logic                    rsp_issued_ff, rsp_issued_in;
   logic                    rsp_stop_ff, rsp_stop_in;
   logic                    rsp_halted_ff, rsp_halted_in;

   // Shared multiplier
   logic [MW-1:0]           mul_a;
   logic [MW-1:0]           mul_b;
   logic [2*MW-1:0]         prod;
   logic [ddrc_pkg::REC_Q_W-1:0] rec_q;
   logic signed [BW:0]      rec_val;

   // Mixing
   logic signed [BW:0]      l_sum;
   logic signed [BW:0]      r_sum;
   logic signed [BW:0]      l_abs;
   logic signed [BW:0]      r_abs;
   logic [BW-1:0]           big_now;

   // Divider
   logic                    div_start;
   logic                    div_done;
   logic [ddrc_pkg::PROD_W-1:0] div_quotient;
   logic signed [W-1:0]     q_s;

   // Tick
   logic [ddrc_pkg::INTERVAL_W-1:0] elapsed_inc;
   logic                    ramp_due;
   logic signed [W-1:0]     next_l;
   logic signed [W-1:0]     next_r;
   logic                    changed;
   logic                    out_free;
   logic signed [BW-1:0]    m_s;

   ddrc_div #(
      .DIVIDEND_W (ddrc_pkg::PROD_W),
      .DIVISOR_W  (BW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod[ddrc_pkg::PROD_W-1:0]),
      .divisor  (big_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Select multiplier operands by sequencer step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ddrc_pkg::BK_MUL_F: begin
            mul_a = MW'(item_ff.fwd_ofs);
            mul_b = MW'(max_pwm);
         end
         ddrc_pkg::BK_MUL_T: begin
            mul_a = MW'(item_ff.turn_ofs);
            mul_b = MW'(max_pwm);
         end
         ddrc_pkg::BK_REC_F, ddrc_pkg::BK_REC_T: begin
            mul_a = acc_ff;
            mul_b = ddrc_pkg::RECIP_100;
         end
         ddrc_pkg::BK_MUL_L: begin
            mul_a = MW'(mag_l_ff);
            mul_b = MW'(max_pwm);
         end
         ddrc_pkg::BK_MUL_R: begin
            mul_a = MW'(mag_r_ff);
            mul_b = MW'(max_pwm);
         end
         default: ;
      endcase
   end

   assign prod    = mul_a * mul_b;
   assign rec_q   = prod[ddrc_pkg::RECIP_SHIFT +: ddrc_pkg::REC_Q_W];
   assign rec_val = $signed({1'b0, rec_q}) - $signed({{(BW+1-ddrc_pkg::PWM_W){1'b0}}, max_pwm});

   // Mix forward and turn
   assign l_sum   = (BW+1)'(f_ff) + (BW+1)'(t_ff);
   assign r_sum   = (BW+1)'(f_ff) - (BW+1)'(t_ff);
   assign l_abs   = l_sum[BW] ? -l_sum : l_sum;
   assign r_abs   = r_sum[BW] ? -r_sum : r_sum;
   assign big_now = (r_abs[BW-1:0] > l_abs[BW-1:0]) ? r_abs[BW-1:0] : l_abs[BW-1:0];
   assign q_s     = $signed({1'b0, div_quotient[W-2:0]});

   // Tick bookkeeping
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign ramp_due    = (elapsed_inc >= ramp_interval);
   assign next_l      = move_toward(level_l_ff, goal_l_ff, ramp_step);
   assign next_r      = move_toward(level_r_ff, goal_r_ff, ramp_step);
   assign changed     = (next_l != level_l_ff) || (next_r != level_r_ff);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign m_s         = $signed({{(BW-ddrc_pkg::PWM_W){1'b0}}, max_pwm});

   // Sequencer: next state, datapath and command execution
   always_comb begin
      state_in        = state_ff;
      item_in         = item_ff;
      acc_in          = acc_ff;
      f_in            = f_ff;
      t_in            = t_ff;
      mag_l_in        = mag_l_ff;
      mag_r_in        = mag_r_ff;
      neg_l_in        = neg_l_ff;
      neg_r_in        = neg_r_ff;
      big_in          = big_ff;
      drv_l_in        = drv_l_ff;
      drv_r_in        = drv_r_ff;
      goal_l_in       = goal_l_ff;
      goal_r_in       = goal_r_ff;
      level_l_in      = level_l_ff;
      level_r_in      = level_r_ff;
      halt_in         = halt_ff;
      elapsed_in      = elapsed_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_left_in     = rsp_left_ff;
      rsp_right_in    = rsp_right_ff;
      rsp_issued_in   = rsp_issued_ff;
      rsp_stop_in     = rsp_stop_ff;
      rsp_halted_in   = rsp_halted_ff;
      pop             = 1'b0;
      div_start       = 1'b0;

      case (state_ff)
         // Take the next entry
         ddrc_pkg::BK_IDLE: begin
            if (!queue_empty) begin
               pop     = 1'b1;
               item_in = head;
               if (head.cmd == ddrc_pkg::CMD_DRIVE && !halt_ff) begin
                  state_in = ddrc_pkg::BK_MUL_F;
               end else begin
                  state_in = ddrc_pkg::BK_FINISH;
               end
            end
         end
         ddrc_pkg::BK_MUL_F: begin
            acc_in   = prod[MW-1:0];
            state_in = ddrc_pkg::BK_REC_F;
         end
         ddrc_pkg::BK_REC_F: begin
            f_in     = rec_val[BW-1:0];
            state_in = ddrc_pkg::BK_MUL_T;
         end
         ddrc_pkg::BK_MUL_T: begin
            acc_in   = prod[MW-1:0];
            state_in = ddrc_pkg::BK_REC_T;
         end
         ddrc_pkg::BK_REC_T: begin
            t_in     = rec_val[BW-1:0];
            state_in = ddrc_pkg::BK_MIX;
         end
         // Mix and decide whether to scale down
         ddrc_pkg::BK_MIX: begin
            mag_l_in = l_abs[BW-1:0];
            mag_r_in = r_abs[BW-1:0];
            neg_l_in = l_sum[BW];
            neg_r_in = r_sum[BW];
            big_in   = big_now;
            drv_l_in = l_sum[W-1:0];
            drv_r_in = r_sum[W-1:0];
            if (big_now > BW'(max_pwm)) begin
               state_in = ddrc_pkg::BK_MUL_L;
            end else begin
               state_in = ddrc_pkg::BK_FINISH;
            end
         end
         ddrc_pkg::BK_MUL_L: begin
            div_start = 1'b1;
            state_in  = ddrc_pkg::BK_DIV_L;
         end
         ddrc_pkg::BK_DIV_L: begin
            if (div_done) begin
               drv_l_in = neg_l_ff ? -q_s : q_s;
               state_in = ddrc_pkg::BK_MUL_R;
            end
         end
         ddrc_pkg::BK_MUL_R: begin
            div_start = 1'b1;
            state_in  = ddrc_pkg::BK_DIV_R;
         end
         ddrc_pkg::BK_DIV_R: begin
            if (div_done) begin
               drv_r_in = neg_r_ff ? -q_s : q_s;
               state_in = ddrc_pkg::BK_FINISH;
            end
         end
         // Commit the command once the result register is free
         ddrc_pkg::BK_FINISH: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = 1'b0;
               rsp_issued_in   = 1'b0;
               rsp_stop_in     = 1'b0;
               state_in        = ddrc_pkg::BK_IDLE;
               case (item_ff.cmd)
                  ddrc_pkg::CMD_TICK: begin
                     if (halt_ff) begin
                        rsp_stop_in = 1'b1;
                     end else begin
                        elapsed_in = elapsed_inc;
                        if (ramp_due) begin
                           elapsed_in = '0;
                           if (changed) begin
                              rsp_issued_in = 1'b1;
                              if (item_ff.driver_ok) begin
                                 level_l_in = next_l;
                                 level_r_in = next_r;
                              end
                           end
                        end
                     end
                  end
                  ddrc_pkg::CMD_DRIVE: begin
                     if (!halt_ff) begin
                        goal_l_in       = drv_l_ff;
                        goal_r_in       = drv_r_ff;
                        rsp_accepted_in = 1'b1;
                     end
                  end
                  ddrc_pkg::CMD_SET_TARGET: begin
                     if (!halt_ff) begin
                        goal_l_in       = item_ff.left_goal;
                        goal_r_in       = item_ff.right_goal;
                        rsp_accepted_in = 1'b1;
                     end
                  end
                  ddrc_pkg::CMD_SOFT_STOP: begin
                     if (!halt_ff) begin
                        goal_l_in = '0;
                        goal_r_in = '0;
                     end
                  end
                  ddrc_pkg::CMD_STOP: begin
                     goal_l_in   = '0;
                     goal_r_in   = '0;
                     level_l_in  = '0;
                     level_r_in  = '0;
                     rsp_stop_in = 1'b1;
                  end
                  ddrc_pkg::CMD_ESTOP: begin
                     halt_in     = 1'b1;
                     goal_l_in   = '0;
                     goal_r_in   = '0;
                     level_l_in  = '0;
                     level_r_in  = '0;
                     rsp_stop_in = 1'b1;
                  end
                  ddrc_pkg::CMD_CLEAR: begin
                     halt_in    = 1'b0;
                     elapsed_in = '0;
                  end
                  default: ;
               endcase
               // Issued speeds, else the levels after the command
               if (rsp_issued_in) begin
                  rsp_left_in  = next_l;
                  rsp_right_in = next_r;
               end else begin
                  rsp_left_in  = level_l_in;
                  rsp_right_in = level_r_in;
               end
               rsp_halted_in = halt_in;
            end
         end
         default: begin
            state_in = ddrc_pkg::BK_IDLE;
         end
      endcase
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ddrc_pkg::BK_IDLE;
         goal_l_ff    <= '0;
         goal_r_ff    <= '0;
         level_l_ff   <= '0;
         level_r_ff   <= '0;
         halt_ff      <= 1'b0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         goal_l_ff    <= goal_l_in;
         goal_r_ff    <= goal_r_in;
         level_l_ff   <= level_l_in;
         level_r_ff   <= level_r_in;
         halt_ff      <= halt_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload
   always_ff @(posedge clock) begin
      item_ff         <= item_in;
      acc_ff          <= acc_in;
      f_ff            <= f_in;
      t_ff            <= t_in;
      mag_l_ff        <= mag_l_in;
      mag_r_ff        <= mag_r_in;
      neg_l_ff        <= neg_l_in;
      neg_r_ff        <= neg_r_in;
      big_ff          <= big_in;
      drv_l_ff        <= drv_l_in;
      drv_r_ff        <= drv_r_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_left_ff     <= rsp_left_in;
      rsp_right_ff    <= rsp_right_in;
      rsp_issued_ff   <= rsp_issued_in;
      rsp_stop_ff     <= rsp_stop_in;
      rsp_halted_ff   <= rsp_halted_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_left_drive    = rsp_left_ff;
   assign rsp_right_drive   = rsp_right_ff;
   assign rsp_speeds_issued = rsp_issued_ff;
   assign rsp_stop_issued   = rsp_stop_ff;
   assign rsp_halted        = rsp_halted_ff;

   a_accept_not_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_accepted_ff && rsp_stop_ff))
      else $error("command both taken and stopped");

   a_issue_not_halted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_issued_ff |-> !rsp_halted_ff)
      else $error("speeds issued while halted");

   a_goal_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_accepted_ff |->
         goal_l_ff <= m_s && goal_l_ff >= -m_s &&
         goal_r_ff <= m_s && goal_r_ff >= -m_s)
      else $error("wheel goal beyond max_pwm");

endmodule

// ===== hdl/differential_drive_ramp_controller_core.sv =====
// Top level of the differential drive ramp controller.
// Holds the configuration registers and wires ddrc_front, ddrc_fifo and ddrc_back.
// Depends on ddrc_pkg.

// Two-wheel drive controller with slew-rate limiting. Each command beat goes
// through a short queue to a back end that executes one command at a time and
// returns exactly one result beat. Tick, set target, stops and clear are
// fetched and then committed in the back end. Drive forms the forward and turn
// values on the sequencer's shared 17x17 multiplier and mixes them; when the
// mix exceeds max_pwm, both wheels are scaled on the multiplier and the
// bit-serial divider. The front end keeps taking beats while the queue has
// room, and the result register lets the back end fetch the next command while
// a result waits. Configuration is at byte addresses 0 (max_pwm), 4 (ramp_step)
// and 8 (ramp_interval_ms); a written 0 is stored as 1.
module differential_drive_ramp_controller_core #(
   parameter int QUEUE_DEPTH = ddrc_pkg::QUEUE_DEPTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [2:0]                              req_command,
   input  logic signed [ddrc_pkg::PCT_W-1:0]       req_forward_percent,
   input  logic signed [ddrc_pkg::PCT_W-1:0]       req_turn_percent,
   input  logic signed [ddrc_pkg::PCT_W-1:0]       req_left_request,
   input  logic signed [ddrc_pkg::PCT_W-1:0]       req_right_request,
   input  logic                                    req_driver_ok,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_accepted,
   output logic signed [ddrc_pkg::WHEEL_W-1:0]     rsp_left_drive,
   output logic signed [ddrc_pkg::WHEEL_W-1:0]     rsp_right_drive,
   output logic                                    rsp_speeds_issued,
   output logic                                    rsp_stop_issued,
   output logic                                    rsp_halted,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [ddrc_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [ddrc_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [ddrc_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                    csr_pready
);

   logic [ddrc_pkg::PWM_W-1:0]      max_pwm_ff, max_pwm_in;
   logic [ddrc_pkg::STEP_W-1:0]     ramp_step_ff, ramp_step_in;
   logic [ddrc_pkg::INTERVAL_W-1:0] interval_ff, interval_in;
   logic [ddrc_pkg::CSR_IDX_W-1:0]  csr_idx;
   logic                            csr_write;

   logic                queue_push;
   logic                queue_pop;
   logic                queue_full;
   logic                queue_empty;
   ddrc_pkg::entry_type push_entry;
   ddrc_pkg::entry_type queue_head;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[ddrc_pkg::CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   // Register writes; a zero is stored as one
   always_comb begin
      max_pwm_in   = max_pwm_ff;
      ramp_step_in = ramp_step_ff;
      interval_in  = interval_ff;
      if (csr_write) begin
         case (csr_idx)
            ddrc_pkg::REG_MAX_PWM: begin
               max_pwm_in = (csr_pwdata[ddrc_pkg::PWM_W-1:0] == '0) ?
                            ddrc_pkg::PWM_W'(1) : csr_pwdata[ddrc_pkg::PWM_W-1:0];
            end
            ddrc_pkg::REG_RAMP_STEP: begin
               ramp_step_in = (csr_pwdata[ddrc_pkg::STEP_W-1:0] == '0) ?
                              ddrc_pkg::STEP_W'(1) : csr_pwdata[ddrc_pkg::STEP_W-1:0];
            end
            ddrc_pkg::REG_RAMP_INTERVAL: begin
               interval_in = (csr_pwdata[ddrc_pkg::INTERVAL_W-1:0] == '0) ?
                             ddrc_pkg::INTERVAL_W'(1) : csr_pwdata[ddrc_pkg::INTERVAL_W-1:0];
            end
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (csr_idx)
         ddrc_pkg::REG_MAX_PWM:       csr_prdata = ddrc_pkg::CSR_DATA_W'(max_pwm_ff);
         ddrc_pkg::REG_RAMP_STEP:     csr_prdata = ddrc_pkg::CSR_DATA_W'(ramp_step_ff);
         ddrc_pkg::REG_RAMP_INTERVAL: csr_prdata = ddrc_pkg::CSR_DATA_W'(interval_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pwm_ff   <= ddrc_pkg::MAX_PWM_RESET;
         ramp_step_ff <= ddrc_pkg::RAMP_STEP_RESET;
         interval_ff  <= ddrc_pkg::RAMP_INTERVAL_RESET;
      end else begin
         max_pwm_ff   <= max_pwm_in;
         ramp_step_ff <= ramp_step_in;
         interval_ff  <= interval_in;
      end
   end

   ddrc_front u_front (
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_forward_percent (req_forward_percent),
      .req_turn_percent    (req_turn_percent),
      .req_left_request    (req_left_request),
      .req_right_request   (req_right_request),
      .req_driver_ok       (req_driver_ok),
      .max_pwm             (max_pwm_ff),
      .queue_full          (queue_full),
      .push                (queue_push),
      .entry               (push_entry)
   );

   ddrc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .pop        (queue_pop),
      .head       (queue_head),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   ddrc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (queue_head),
      .queue_empty       (queue_empty),
      .pop               (queue_pop),
      .max_pwm           (max_pwm_ff),
      .ramp_step         (ramp_step_ff),
      .ramp_interval     (interval_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_left_drive    (rsp_left_drive),
      .rsp_right_drive   (rsp_right_drive),
      .rsp_speeds_issued (rsp_speeds_issued),
      .rsp_stop_issued   (rsp_stop_issued),
      .rsp_halted        (rsp_halted)
   );

endmodule
